### rtl/core/assert_macros.svh
// assertion macros used by the port level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check under reset
`define BTU_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication check under reset
`define BTU_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### rtl/core/btu_pkg.sv
// package for the breakpoint table unit: types, codes and opcode classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package btu_pkg;
  localparam int unsigned EntriesDef = 16;
  localparam logic [31:0] BreakOp = 32'h0000_000d;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_ADD_CB = 3'd1, CMD_DEL = 3'd2, CMD_TRAP = 3'd3, CMD_RESUME = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_ADDED = 4'd0, ST_MISALIGN = 4'd1, ST_DUP = 4'd2, ST_ADJ = 4'd3, ST_FULL = 4'd4,
    ST_DELETED = 4'd5, ST_BADIDX = 4'd6, ST_EMPTY = 4'd7, ST_OS_BUSY = 4'd8,
    ST_HIT = 4'd9, ST_REARM = 4'd10, ST_UNKNOWN = 4'd11, ST_DSLOT = 4'd12,
    ST_RESUMED = 4'd13, ST_NONE = 4'd14
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_CONSOLE = 2'd1, ACT_CALLBACK = 2'd2
  } action_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] target_address;
    logic [7:0]  slot_number;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] handler_target;
    logic        in_delay_slot;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  entry;
    logic [31:0] patch_address;
    logic        first_write;
    logic [31:0] first_data;
    logic        second_write;
    logic [31:0] second_data;
    logic        advance_pc;
    logic [1:0]  action;
    logic [31:0] callback_target;
    logic [31:0] hit_count;
    logic        recursion_warning;
  } rsp_t;

  localparam int unsigned JmpLen = 23;
  localparam logic [31:0] JmpMask [JmpLen] = '{
    32'hf3ff0000, 32'hf3ff0000, 32'hf3ff0000, 32'hf3ff0000,
    32'hfc000000, 32'hfc000000,
    32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000,
    32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000,
    32'hfc1f0000, 32'hfc1f0000,
    32'hfc000000, 32'hfc000000, 32'hfc000000, 32'hfc000000,
    32'hfc1f07ff};
  localparam logic [31:0] JmpVal [JmpLen] = '{
    32'h41000000, 32'h41020000, 32'h41010000, 32'h41030000,
    32'h10000000, 32'h50000000,
    32'h04010000, 32'h04110000, 32'h04130000, 32'h04030000, 32'h1c000000,
    32'h5c000000, 32'h18000000, 32'h58000000, 32'h04000000, 32'h04100000,
    32'h04120000, 32'h04020000,
    32'h14000000, 32'h54000000, 32'h08000000, 32'h0c000000,
    32'h00000009};

  function automatic logic branch_like(input logic [31:0] w);
    logic r;
    r = 1'b0;
    for (int k = 0; k < JmpLen; k++) begin
      if ((w & JmpMask[k]) == JmpVal[k]) r = 1'b1;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/core/btu_front.sv
// front end: accepts requests, drops unknown commands, tags one-shot adds
// depends on btu_pkg
`timescale 1ns / 1ps
`default_nettype none
module btu_front import btu_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic q_valid_o,
  input  wire  q_stall_i,
  output req_t q_req_o,
  output logic q_oneshot_o
);
  logic valid_q, valid_d;
  req_t req_q;
  logic os_q;
  logic take;

  // single entry queue; refills while the back end drains it
  assign req_stall_o = valid_q && q_stall_i;
  assign take = req_valid_i && !req_stall_o && (req_i.command <= CMD_RESUME);

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !q_stall_i) valid_d = 1'b0;
    if (take) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_i;
      os_q  <= branch_like(req_i.first_word);
    end
  end

  assign q_valid_o   = valid_q;
  assign q_req_o     = req_q;
  assign q_oneshot_o = os_q;
endmodule
`default_nettype wire

### rtl/core/btu_back.sv
// back end: slot table, parallel compares, result register
// depends on btu_pkg
`timescale 1ns / 1ps
`default_nettype none
module btu_back import btu_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  q_valid_i,
  output logic q_stall_o,
  input  req_t q_req_i,
  input  wire  q_oneshot_i,
  output logic rsp_valid_o,
  input  wire  rsp_stall_i,
  output rsp_t rsp_o
);
  localparam int unsigned Iw = (Entries > 1) ? $clog2(Entries) : 1;

  logic [31:0] addr_q [Entries];
  logic [3:0]  flags_q [Entries];
  logic [31:0] w1_q [Entries];
  logic [31:0] w2_q [Entries];
  logic [31:0] hits_q [Entries];
  logic [31:0] hand_q [Entries];
  logic        pv_q;
  logic [Iw-1:0] ps_q;
  logic [31:0] pa_q;
  logic        ov_q;
  rsp_t        rsp_q;

  logic        go;
  rsp_t        r;
  logic        conf_f, free_f, hit_f;
  logic [Iw-1:0] conf_i, free_i, hit_i, n;
  logic        conf_dup;
  logic [31:0] a;

  assign q_stall_o = ov_q && rsp_stall_i;
  assign go = q_valid_i && !q_stall_o;
  assign a = q_req_i.target_address;
  assign n = q_req_i.slot_number[Iw-1:0];

  // priority scans over the slot compares
  always_comb begin
    conf_f = 1'b0; conf_i = '0; conf_dup = 1'b0;
    free_f = 1'b0; free_i = '0;
    hit_f = 1'b0; hit_i = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (addr_q[i] == a || addr_q[i] == a + 32'd4 || addr_q[i] == a - 32'd4) begin
        conf_f = 1'b1; conf_i = Iw'(i); conf_dup = (addr_q[i] == a);
      end
      if (addr_q[i] == 32'd0) begin
        free_f = 1'b1; free_i = Iw'(i);
      end
      if (addr_q[i] != 32'd0 &&
          ((!flags_q[i][3] && a == addr_q[i]) || (flags_q[i][3] && a == addr_q[i] + 32'd4))) begin
        hit_f = 1'b1; hit_i = Iw'(i);
      end
    end
  end

  logic [31:0] nh;
  assign nh = hits_q[hit_i] + 32'd1;

  always_comb begin
    r = '0;
    unique case (cmd_e'(q_req_i.command))
      CMD_ADD, CMD_ADD_CB: begin
        if (a[1:0] != 2'b00) r.status = ST_MISALIGN;
        else if (conf_f) begin
          r.status = conf_dup ? ST_DUP : ST_ADJ; r.entry = 8'(conf_i);
        end else if (!free_f) r.status = ST_FULL;
        else begin
          r.status = ST_ADDED; r.entry = 8'(free_i); r.patch_address = a;
          r.first_write = 1'b1; r.first_data = BreakOp;
        end
      end
      CMD_DEL: begin
        r.entry = q_req_i.slot_number;
        if (32'(q_req_i.slot_number) >= Entries) r.status = ST_BADIDX;
        else if (addr_q[n] == 32'd0) r.status = ST_EMPTY;
        else if (flags_q[n][0] && flags_q[n][1]) r.status = ST_OS_BUSY;
        else begin
          r.status = ST_DELETED; r.patch_address = addr_q[n];
          r.first_write = 1'b1; r.first_data = w1_q[n];
          r.second_write = 1'b1; r.second_data = w2_q[n];
        end
      end
      CMD_TRAP: begin
        if (q_req_i.in_delay_slot) r.status = ST_DSLOT;
        else if (!hit_f) begin
          r.status = ST_UNKNOWN; r.advance_pc = 1'b1; r.action = ACT_CONSOLE;
        end else begin
          r.entry = 8'(hit_i); r.patch_address = addr_q[hit_i];
          r.first_write = 1'b1;
          if (flags_q[hit_i][3]) begin
            r.status = ST_REARM; r.first_data = BreakOp;
            r.second_write = 1'b1; r.second_data = w2_q[hit_i];
            r.hit_count = hits_q[hit_i];
          end else begin
            r.status = ST_HIT; r.first_data = w1_q[hit_i];
            r.recursion_warning = flags_q[hit_i][0];
            if (!flags_q[hit_i][1]) begin
              r.second_write = 1'b1; r.second_data = BreakOp;
            end
            r.hit_count = nh;
            if (flags_q[hit_i][2]) begin
              if (hand_q[hit_i] != 32'd0) begin
                r.action = ACT_CALLBACK; r.callback_target = hand_q[hit_i];
              end
            end else r.action = ACT_CONSOLE;
          end
        end
      end
      CMD_RESUME: begin
        if (!pv_q) r.status = ST_NONE;
        else begin
          r.status = ST_RESUMED; r.entry = 8'(ps_q);
        end
      end
      default: r = '0;
    endcase
  end

  // table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        addr_q[i] <= '0; flags_q[i] <= '0;
      end
      pv_q <= 1'b0; ps_q <= '0; pa_q <= '0;
    end else if (go) begin
      case (cmd_e'(q_req_i.command))
        CMD_ADD, CMD_ADD_CB: begin
          if (a[1:0] == 2'b00 && !conf_f && free_f) begin
            addr_q[free_i] <= a;
            flags_q[free_i] <= {1'b0, q_req_i.command == CMD_ADD_CB, q_oneshot_i, 1'b0};
          end
        end
        CMD_DEL: begin
          if (r.status == ST_DELETED) begin
            addr_q[n] <= '0; flags_q[n] <= '0;
          end
        end
        CMD_TRAP: begin
          if (r.status == ST_REARM) flags_q[hit_i][3] <= 1'b0;
          else if (r.status == ST_HIT) begin
            flags_q[hit_i][0] <= 1'b1;
            if (!flags_q[hit_i][1]) flags_q[hit_i][3] <= 1'b1;
            pv_q <= 1'b1; ps_q <= hit_i; pa_q <= a;
          end
        end
        CMD_RESUME: begin
          if (pv_q) begin
            pv_q <= 1'b0;
            if (addr_q[ps_q] == pa_q && flags_q[ps_q][0]) begin
              if (flags_q[ps_q][1]) addr_q[ps_q] <= '0;
              flags_q[ps_q][0] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload stores, written by add and hit only
  always_ff @(posedge clk_i) begin
    if (go && r.status == ST_ADDED &&
        (q_req_i.command == CMD_ADD || q_req_i.command == CMD_ADD_CB)) begin
      w1_q[free_i] <= q_req_i.first_word;
      w2_q[free_i] <= q_req_i.second_word;
      hits_q[free_i] <= '0;
      hand_q[free_i] <= (q_req_i.command == CMD_ADD_CB) ? q_req_i.handler_target : '0;
    end
    if (go && q_req_i.command == CMD_TRAP && r.status == ST_HIT) hits_q[hit_i] <= nh;
    if (go) rsp_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (go) ov_q <= 1'b1;
    else if (!rsp_stall_i) ov_q <= 1'b0;
  end

  assign rsp_valid_o = ov_q;
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

### rtl/core/breakpoint_table_unit.sv
// breakpoint table unit top level: front queue plus back end table
// depends on btu_pkg, btu_front, btu_back
//   channel  | direction | valid       | stall       | payload
//   request  | in        | req_valid_i | req_stall_o | req_i (req_t)
//   result   | out       | rsp_valid_o | rsp_stall_i | rsp_o (rsp_t)
// a request passes through the front register and then the back end result
// register; throughput is one per cycle while the result side drains, set by
// the single result register of the back end
// reset clears the slot addresses, flags and pending hit at once
// a stalled result backs up into the front register, then stalls the request
`timescale 1ns / 1ps
`default_nettype none
module breakpoint_table_unit import btu_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  wire  rsp_stall_i,
  output rsp_t rsp_o
);
  logic q_valid, q_stall, q_os;
  req_t q_req;

  // classify and hold
  btu_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .q_valid_o(q_valid), .q_stall_i(q_stall), .q_req_o(q_req), .q_oneshot_o(q_os)
  );

  // execute against the table
  btu_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_stall_o(q_stall), .q_req_i(q_req),
    .q_oneshot_i(q_os), .rsp_valid_o, .rsp_stall_i, .rsp_o
  );
endmodule
`default_nettype wire

### rtl/core/btu_checker.sv
// port level checker for the breakpoint table unit, bound to the top level
// depends on btu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module btu_checker import btu_pkg::*; (
  input wire  clk_i,
  input wire  rst_ni,
  input wire  req_valid_i,
  input wire  req_stall_o,
  input req_t req_i,
  input wire  rsp_valid_o,
  input wire  rsp_stall_i,
  input rsp_t rsp_o
);
  `BTU_ASSERT_NXT(a_req_hold, clk_i, rst_ni, req_valid_i && req_stall_o, req_valid_i && $stable(req_i))
  `BTU_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && rsp_stall_i, rsp_valid_o && $stable(rsp_o))
  `BTU_ASSERT_IMP(a_status_rng, clk_i, rst_ni, rsp_valid_o, rsp_o.status <= ST_NONE)
  `BTU_ASSERT_IMP(a_no_data, clk_i, rst_ni, rsp_valid_o && !rsp_o.first_write, rsp_o.first_data == 32'd0)
  `BTU_ASSERT_IMP(a_adv, clk_i, rst_ni, rsp_valid_o && rsp_o.advance_pc, rsp_o.status == ST_UNKNOWN)
endmodule
bind breakpoint_table_unit btu_checker u_btu_checker (.*);
`default_nettype wire

### dv/breakpoint_table_checker.sv
// result checker for the breakpoint table unit: watches both channels,
// predicts each result from its own table copy and compares field by field
// depends on btu_pkg
`timescale 1ns / 1ps
module breakpoint_table_checker import btu_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  req_t        req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_stall_i,
  input  rsp_t        rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_count_o
);
  localparam logic [3:0] FlagInProg = 4'h1;
  localparam logic [3:0] FlagOneShot = 4'h2;
  localparam logic [3:0] FlagCall = 4'h4;
  localparam logic [3:0] FlagReinst = 4'h8;

  logic [31:0] tbl_addr [Entries];
  logic [31:0] tbl_word0 [Entries];
  logic [31:0] tbl_word1 [Entries];
  logic [3:0]  tbl_flags [Entries];
  logic [31:0] tbl_hits [Entries];
  logic [31:0] tbl_handler [Entries];
  logic        hit_open;
  int unsigned hit_slot;
  logic [31:0] hit_pc;
  rsp_t        expected_rsps [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_count_o = expected_rsps.size();

  function automatic logic is_branch(input logic [31:0] w);
    logic [31:0] m [23];
    logic [31:0] v [23];
    m = '{32'hf3ff0000, 32'hf3ff0000, 32'hf3ff0000, 32'hf3ff0000,
          32'hfc000000, 32'hfc000000,
          32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000,
          32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000, 32'hfc1f0000,
          32'hfc1f0000, 32'hfc1f0000,
          32'hfc000000, 32'hfc000000, 32'hfc000000, 32'hfc000000, 32'hfc1f07ff};
    v = '{32'h41000000, 32'h41020000, 32'h41010000, 32'h41030000,
          32'h10000000, 32'h50000000,
          32'h04010000, 32'h04110000, 32'h04130000, 32'h04030000, 32'h1c000000,
          32'h5c000000, 32'h18000000, 32'h58000000, 32'h04000000, 32'h04100000,
          32'h04120000, 32'h04020000,
          32'h14000000, 32'h54000000, 32'h08000000, 32'h0c000000, 32'h00000009};
    for (int k = 0; k < 23; k++) if ((w & m[k]) == v[k]) return 1'b1;
    return 1'b0;
  endfunction

  // works out the result of one request and updates the table copy
  function automatic rsp_t apply_request(input req_t rq);
    rsp_t r;
    int   s;
    r = '0;
    s = -1;
    case (cmd_e'(rq.command))
      CMD_ADD, CMD_ADD_CB: begin
        if (rq.target_address[1:0] != 2'b00) begin
          r.status = ST_MISALIGN;
          return r;
        end
        for (int i = 0; i < Entries; i++) begin
          if (tbl_addr[i] == rq.target_address) begin
            r.status = ST_DUP;
            r.entry = 8'(i);
            return r;
          end
          if (tbl_addr[i] == rq.target_address + 32'd4 ||
              tbl_addr[i] == rq.target_address - 32'd4) begin
            r.status = ST_ADJ;
            r.entry = 8'(i);
            return r;
          end
        end
        for (int i = Entries - 1; i >= 0; i--) if (tbl_addr[i] == '0) s = i;
        if (s < 0) begin
          r.status = ST_FULL;
          return r;
        end
        tbl_addr[s] = rq.target_address;
        tbl_word0[s] = rq.first_word;
        tbl_word1[s] = rq.second_word;
        tbl_flags[s] = (rq.command == CMD_ADD_CB) ? FlagCall : '0;
        tbl_handler[s] = (rq.command == CMD_ADD_CB) ? rq.handler_target : '0;
        if (is_branch(rq.first_word)) tbl_flags[s] |= FlagOneShot;
        tbl_hits[s] = '0;
        r.status = ST_ADDED;
        r.entry = 8'(s);
        r.patch_address = rq.target_address;
        r.first_write = 1'b1;
        r.first_data = BreakOp;
      end
      CMD_DEL: begin
        r.entry = rq.slot_number;
        if (rq.slot_number >= Entries) r.status = ST_BADIDX;
        else if (tbl_addr[rq.slot_number] == '0) r.status = ST_EMPTY;
        else if ((tbl_flags[rq.slot_number] & FlagInProg) != 0 &&
                 (tbl_flags[rq.slot_number] & FlagOneShot) != 0) r.status = ST_OS_BUSY;
        else begin
          s = int'(rq.slot_number);
          r.status = ST_DELETED;
          r.patch_address = tbl_addr[s];
          r.first_write = 1'b1;
          r.first_data = tbl_word0[s];
          r.second_write = 1'b1;
          r.second_data = tbl_word1[s];
          tbl_addr[s] = '0;
          tbl_flags[s] = '0;
        end
      end
      CMD_TRAP: begin
        if (rq.in_delay_slot) begin
          r.status = ST_DSLOT;
          return r;
        end
        for (int i = Entries - 1; i >= 0; i--) begin
          if (tbl_addr[i] != '0 &&
              (((tbl_flags[i] & FlagReinst) == 0 && rq.target_address == tbl_addr[i]) ||
               ((tbl_flags[i] & FlagReinst) != 0 &&
                rq.target_address == tbl_addr[i] + 32'd4))) s = i;
        end
        if (s < 0) begin
          r.status = ST_UNKNOWN;
          r.advance_pc = 1'b1;
          r.action = ACT_CONSOLE;
          return r;
        end
        r.entry = 8'(s);
        r.patch_address = tbl_addr[s];
        r.first_write = 1'b1;
        if ((tbl_flags[s] & FlagReinst) != 0) begin
          // second-word trap: break goes back on the first word
          r.status = ST_REARM;
          r.first_data = BreakOp;
          r.second_write = 1'b1;
          r.second_data = tbl_word1[s];
          r.hit_count = tbl_hits[s];
          tbl_flags[s] &= ~FlagReinst;
          return r;
        end
        r.status = ST_HIT;
        r.recursion_warning = (tbl_flags[s] & FlagInProg) != 0;
        r.first_data = tbl_word0[s];
        if ((tbl_flags[s] & FlagOneShot) == 0) begin
          r.second_write = 1'b1;
          r.second_data = BreakOp;
          tbl_flags[s] |= FlagReinst;
        end
        tbl_flags[s] |= FlagInProg;
        tbl_hits[s] += 32'd1;
        r.hit_count = tbl_hits[s];
        if ((tbl_flags[s] & FlagCall) != 0) begin
          if (tbl_handler[s] != '0) begin
            r.action = ACT_CALLBACK;
            r.callback_target = tbl_handler[s];
          end
        end else r.action = ACT_CONSOLE;
        hit_open = 1'b1;
        hit_slot = s;
        hit_pc = rq.target_address;
      end
      CMD_RESUME: begin
        if (!hit_open) begin
          r.status = ST_NONE;
          return r;
        end
        r.status = ST_RESUMED;
        hit_open = 1'b0;
        r.entry = 8'(hit_slot);
        if (tbl_addr[hit_slot] == hit_pc && (tbl_flags[hit_slot] & FlagInProg) != 0) begin
          if ((tbl_flags[hit_slot] & FlagOneShot) != 0) tbl_addr[hit_slot] = '0;
          tbl_flags[hit_slot] &= ~FlagInProg;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t w;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        tbl_addr[i] <= '0;
        tbl_flags[i] <= '0;
        tbl_word0[i] <= '0;
        tbl_word1[i] <= '0;
        tbl_hits[i] <= '0;
        tbl_handler[i] <= '0;
      end
      hit_open <= 1'b0;
      hit_slot <= 0;
      hit_pc <= '0;
      fails <= 0;
    end else begin
      if (req_valid_i && !req_stall_i && req_i.command <= CMD_RESUME)
        expected_rsps.push_back(apply_request(req_i));
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsps.size() == 0)
          report_mismatch("unexpected result", 32'(rsp_i.status), '0);
        else begin
          w = expected_rsps.pop_front();
          if (rsp_i.status != w.status)
            report_mismatch("status", 32'(rsp_i.status), 32'(w.status));
          if (rsp_i.entry != w.entry)
            report_mismatch("entry", 32'(rsp_i.entry), 32'(w.entry));
          if (rsp_i.patch_address != w.patch_address)
            report_mismatch("patch_address", rsp_i.patch_address, w.patch_address);
          if (rsp_i.first_write != w.first_write)
            report_mismatch("first_write", 32'(rsp_i.first_write), 32'(w.first_write));
          if (rsp_i.first_data != w.first_data)
            report_mismatch("first_data", rsp_i.first_data, w.first_data);
          if (rsp_i.second_write != w.second_write)
            report_mismatch("second_write", 32'(rsp_i.second_write), 32'(w.second_write));
          if (rsp_i.second_data != w.second_data)
            report_mismatch("second_data", rsp_i.second_data, w.second_data);
          if (rsp_i.advance_pc != w.advance_pc)
            report_mismatch("advance_pc", 32'(rsp_i.advance_pc), 32'(w.advance_pc));
          if (rsp_i.action != w.action)
            report_mismatch("action", 32'(rsp_i.action), 32'(w.action));
          if (rsp_i.callback_target != w.callback_target)
            report_mismatch("callback_target", rsp_i.callback_target, w.callback_target);
          if (rsp_i.hit_count != w.hit_count)
            report_mismatch("hit_count", rsp_i.hit_count, w.hit_count);
          if (rsp_i.recursion_warning != w.recursion_warning)
            report_mismatch("recursion_warning", 32'(rsp_i.recursion_warning),
                            32'(w.recursion_warning));
        end
      end
    end
  end
endmodule

### dv/breakpoint_table_unit_test.sv
// testbench top for the breakpoint table unit: clock, reset, request
// stimulus, result stall and verdict; depends on btu_pkg,
// breakpoint_table_unit and breakpoint_table_checker
`timescale 1ns / 1ps
module breakpoint_table_unit_test;
  import btu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  logic        long_hold = 1'b0;   // result side held off for a long stretch
  logic        stim_done = 1'b0;

  // small pool of breakpoint addresses so adds, traps and deletes collide
  logic [31:0] addr_pool [12];

  always #1 clk = ~clk;

  breakpoint_table_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_o (req_stall),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_o       (rsp)
  );

  breakpoint_table_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_valid),
    .req_stall_i     (req_stall),
    .req_i           (req),
    .rsp_valid_i     (rsp_valid),
    .rsp_stall_i     (rsp_stall),
    .rsp_i           (rsp),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // idle length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one request and hold it until the block takes it; stall is
  // sampled at the falling edge, where it holds the value the next
  // rising edge sees; valid stays high across back to back requests
  task automatic send_request(input req_t r);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(negedge clk);
    while (req_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // random request: mostly commands on pool addresses, some raw noise
  function automatic req_t random_request();
    req_t r;
    int unsigned p;
    r.command = 3'($urandom_range(0, 4));
    r.target_address = $urandom();
    r.slot_number = 8'($urandom());
    r.first_word = $urandom();
    r.second_word = $urandom();
    r.handler_target = $urandom();
    r.in_delay_slot = ($urandom_range(0, 15) == 0);
    p = $urandom_range(0, 99);
    if (p < 85) begin
      r.target_address = addr_pool[$urandom_range(0, 11)];
      // trap on the second word of a rearming entry
      if (r.command == CMD_TRAP && $urandom_range(0, 2) == 0) r.target_address += 32'd4;
    end else if (p < 88) r.target_address = {$urandom_range(0, 1) ? 30'h3fffffff : 30'h0,
                                            2'($urandom())};
    if ($urandom_range(0, 3) != 0) r.slot_number = 8'($urandom_range(0, 17));
    if ($urandom_range(0, 2) == 0) r.first_word = 32'h0800_0000 | 32'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0) r.handler_target = '0;
    if ($urandom_range(0, 40) == 0) r.command = 3'($urandom_range(5, 7));
    return r;
  endfunction

  function automatic req_t mk(input cmd_e c, input logic [31:0] a, input logic [7:0] n,
                              input logic [31:0] w0, input logic [31:0] h,
                              input logic ds);
    req_t r;
    r.command = c;
    r.target_address = a;
    r.slot_number = n;
    r.first_word = w0;
    r.second_word = ~w0;
    r.handler_target = h;
    r.in_delay_slot = ds;
    return r;
  endfunction

  // result stall: random gaps plus the long hold-off window
  initial begin
    @(posedge rst_n);
    while (1) begin
      @(posedge clk);
      if (long_hold) rsp_stall <= 1'b1;
      else if (cycle_count % 2000 < 400) rsp_stall <= 1'b0;  // stretch with no stall
      else rsp_stall <= (gap_len() > 1);
    end
  end

  // long hold-off: the sender keeps offering while results back up
  initial begin
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    long_hold <= 1'b1;
    repeat (200) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("breakpoint_table_unit_test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 12; i++) addr_pool[i] = 32'h8000_1000 + 32'(i * 8);
    addr_pool[10] = 32'hffff_fffc;
    addr_pool[11] = 32'h8000_1004;  // adjacent to the first
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty-slot conflicts, misaligned, duplicates, adjacent, deletes, traps, callbacks, resumes
    send_request(mk(CMD_ADD, 32'h0, 0, 0, 0, 0));
    send_request(mk(CMD_ADD, 32'h4, 0, 0, 0, 0));
    send_request(mk(CMD_ADD, 32'hffff_fffc, 0, 0, 0, 0));
    send_request(mk(CMD_ADD, 32'h8000_0002, 0, 0, 0, 0));
    send_request(mk(CMD_RESUME, 0, 0, 0, 0, 0));
    send_request(mk(CMD_DEL, 0, 8'hff, 0, 0, 0));
    send_request(mk(CMD_DEL, 0, 8'd3, 0, 0, 0));
    send_request(mk(CMD_ADD, 32'h8000_0000, 0, 32'h2402_0001, 0, 0));
    send_request(mk(CMD_ADD, 32'h8000_0000, 0, 0, 0, 0));
    send_request(mk(CMD_ADD, 32'h8000_0004, 0, 0, 0, 0));
    send_request(mk(CMD_ADD_CB, 32'h8000_0100, 0, 32'h0000_0009, 32'hdead_beec, 0));
    send_request(mk(CMD_ADD_CB, 32'h8000_0200, 0, 32'hffff_ffff, 32'h0, 0));
    send_request(mk(CMD_TRAP, 32'h8000_0000, 0, 0, 0, 1));
    send_request(mk(CMD_TRAP, 32'h8000_0000, 0, 0, 0, 0));
    send_request(mk(CMD_TRAP, 32'h8000_0004, 0, 0, 0, 0));
    send_request(mk(CMD_TRAP, 32'h8000_0100, 0, 0, 0, 0));
    send_request(mk(CMD_DEL, 0, 8'd1, 0, 0, 0));
    send_request(mk(CMD_TRAP, 32'h8000_0200, 0, 0, 0, 0));
    send_request(mk(CMD_TRAP, 32'h1234_5678, 0, 0, 0, 0));
    send_request(mk(CMD_RESUME, 0, 0, 0, 0, 0));
    send_request(mk(CMD_DEL, 0, 8'd15, 0, 0, 0));
    send_request(mk(CMD_DEL, 0, 8'd16, 0, 0, 0));
    send_request(mk(cmd_e'(3'd7), 32'hffff_ffff, 8'hff, '1, '1, 1));
    // random part
    for (int n = 0; n < 1950; n++) send_request(random_request());
    // fill the table to full, then one more add
    for (int i = 0; i < 18; i++)
      send_request(mk(CMD_ADD, 32'h9000_0000 + 32'(i * 16), 0, 32'h1, 0, 0));
    send_request(mk(CMD_ADD, 32'h9100_0000, 0, 32'h1, 0, 0));
    req_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("breakpoint_table_unit_test passed");
    else $display("breakpoint_table_unit_test failed");
    $finish;
  end
endmodule
